// ----- rtl/erpt_pkg.sv -----
// shared types, constants and tables of the euler rigid point transform
package erpt_pkg;

  localparam int unsigned CoordW      = 32;
  localparam int unsigned BasisFb     = 16;
  localparam int unsigned AngleW      = 16;
  localparam int unsigned BasisW      = BasisFb + 2;
  localparam int unsigned DiffW       = CoordW + 1;
  localparam int unsigned ProdW       = BasisW + DiffW;
  localparam int unsigned SumW        = ProdW + 2;
  localparam int unsigned CfgW        = (CoordW > AngleW) ? CoordW : AngleW;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CordicSteps = 24;
  localparam int unsigned StepW       = 5;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QueuePtrW   = 2;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [31:0]       q30_t;
  typedef logic [8:0][BasisW-1:0]   basis_t;

  localparam q30_t Q30One     = 32'sh4000_0000;
  localparam q30_t CordicGain = 32'sd652032874;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PITCH    = 3'd0,
    REG_YAW      = 3'd1,
    REG_ROLL     = 3'd2,
    REG_OFFSET_X = 3'd3,
    REG_OFFSET_Y = 3'd4,
    REG_OFFSET_Z = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    ACT_TO_WORLD = 1'b0,
    ACT_TO_LOCAL = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_ROT,
    BS_FIN,
    BS_MAC
  } basis_state_e;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  typedef struct packed {
    action_e action;
    vec_t    p;
  } request_t;

  // arctangent of 2^-i in units of 2^32 per turn
  function automatic logic signed [32:0] atan_step(input logic [StepW-1:0] i);
    logic signed [32:0] r;
    case (i)
      5'd0:    r = 33'sd536870912;
      5'd1:    r = 33'sd316933406;
      5'd2:    r = 33'sd167458907;
      5'd3:    r = 33'sd85004756;
      5'd4:    r = 33'sd42667331;
      5'd5:    r = 33'sd21354465;
      5'd6:    r = 33'sd10679838;
      5'd7:    r = 33'sd5340245;
      5'd8:    r = 33'sd2670163;
      5'd9:    r = 33'sd1335087;
      5'd10:   r = 33'sd667544;
      5'd11:   r = 33'sd333772;
      5'd12:   r = 33'sd166886;
      5'd13:   r = 33'sd83443;
      5'd14:   r = 33'sd41722;
      5'd15:   r = 33'sd20861;
      5'd16:   r = 33'sd10430;
      5'd17:   r = 33'sd5215;
      5'd18:   r = 33'sd2608;
      5'd19:   r = 33'sd1304;
      5'd20:   r = 33'sd652;
      5'd21:   r = 33'sd326;
      5'd22:   r = 33'sd163;
      5'd23:   r = 33'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic basis_t ident_basis();
    basis_t b;
    for (int e = 0; e < 9; e++) begin
      b[e] = (e % 4 == 0) ? BasisW'(1) << BasisFb : '0;
    end
    return b;
  endfunction

  function automatic logic [3:0] idx3(input logic [1:0] r, input logic [1:0] c);
    return 4'(r) * 4'd3 + 4'(c);
  endfunction

endpackage

// ----- rtl/erpt_front.sv -----
// front end: request intake and queue toward the datapath
module erpt_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  erpt_pkg::request_t req_i,
  input  logic               basis_busy_i,
  output logic               stall_o,
  input  logic               pop_i,
  output logic               avail_o,
  output erpt_pkg::request_t req_o
);

  erpt_pkg::request_t                  mem_q [erpt_pkg::QueueDepth];
  logic [erpt_pkg::QueuePtrW-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [erpt_pkg::QueuePtrW:0]        cnt_q, cnt_d;
  logic                                push;

  assign stall_o = (cnt_q == (erpt_pkg::QueuePtrW + 1)'(erpt_pkg::QueueDepth)) || basis_busy_i;
  assign push    = in_valid_i && !stall_o;
  assign avail_o = (cnt_q != '0);
  assign req_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= req_i;
    end
  end

endmodule

// ----- rtl/erpt_basis.sv -----
// rotation basis builder: shared cordic for three angles, then two 3x3 products on one multiplier
module erpt_basis (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         stale_set_i,
  input  logic [erpt_pkg::AngleW-1:0]  pitch_i,
  input  logic [erpt_pkg::AngleW-1:0]  yaw_i,
  input  logic [erpt_pkg::AngleW-1:0]  roll_i,
  output logic                         busy_o,
  output erpt_pkg::basis_t             basis_o
);

  localparam int unsigned BasisSh = 30 - erpt_pkg::BasisFb;
  localparam int unsigned RndSh   = (erpt_pkg::BasisFb < 30) ? 29 - erpt_pkg::BasisFb : 0;
  localparam logic signed [63:0] RndAdd = (erpt_pkg::BasisFb < 30) ? (64'sd1 <<< RndSh) : 64'sd0;
  localparam logic signed [33:0] UnitB  = 34'sd1 <<< erpt_pkg::BasisFb;
  localparam logic signed [33:0] UnitQ  = 34'sd1 <<< 30;

  erpt_pkg::basis_state_e st_q, st_d;
  logic                   stale_q, stale_d;
  logic [1:0]             ang_q, ang_d, quad_q, quad_d;
  logic [erpt_pkg::StepW-1:0] it_q, it_d;
  logic signed [33:0]     x_q, x_d, y_q, y_d;
  logic signed [32:0]     z_q, z_d;
  erpt_pkg::q30_t         c_q [3], c_d [3], s_q [3], s_d [3];
  logic                   ph_q, ph_d, sub_q, sub_d;
  logic [1:0]             i_q, i_d, j_q, j_d, k_q, k_d;
  logic signed [63:0]     acc_q, acc_d, prod_q, prod_d;
  erpt_pkg::q30_t         t_q [9], t_d [9];
  erpt_pkg::basis_t       basis_q, basis_d;

  erpt_pkg::q30_t         ym [9], pm [9], rm [9];
  erpt_pkg::q30_t         a_op, b_op, xc, yc;
  logic [erpt_pkg::AngleW-1:0] ang_val;
  logic [31:0]            phase;
  logic signed [33:0]     dx, dy;
  logic signed [63:0]     sum;
  logic signed [33:0]     res, rv;
  logic [3:0]             e_idx;

  assign busy_o  = stale_q || (st_q != erpt_pkg::BS_IDLE);
  assign basis_o = basis_q;

  always_comb begin
    ym = '{c_q[1], 32'sd0, -s_q[1], 32'sd0, erpt_pkg::Q30One, 32'sd0, s_q[1], 32'sd0, c_q[1]};
    pm = '{erpt_pkg::Q30One, 32'sd0, 32'sd0, 32'sd0, c_q[0], s_q[0], 32'sd0, -s_q[0], c_q[0]};
    rm = '{c_q[2], -s_q[2], 32'sd0, s_q[2], c_q[2], 32'sd0, 32'sd0, 32'sd0, erpt_pkg::Q30One};
  end

  always_comb begin
    st_d    = st_q;
    stale_d = stale_q;
    ang_d   = ang_q;
    quad_d  = quad_q;
    it_d    = it_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    c_d     = c_q;
    s_d     = s_q;
    ph_d    = ph_q;
    sub_d   = sub_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    acc_d   = acc_q;
    prod_d  = prod_q;
    t_d     = t_q;
    basis_d = basis_q;

    case ((st_q == erpt_pkg::BS_FIN) ? ang_q + 2'd1 : 2'd0)
      2'd1:    ang_val = yaw_i;
      2'd2:    ang_val = roll_i;
      default: ang_val = pitch_i;
    endcase
    phase = 32'(ang_val) << (32 - erpt_pkg::AngleW);

    dx = y_q >>> it_q;
    dy = x_q >>> it_q;

    xc = (x_q > UnitQ) ? erpt_pkg::Q30One : (x_q < -UnitQ) ? -erpt_pkg::Q30One : x_q[31:0];
    yc = (y_q > UnitQ) ? erpt_pkg::Q30One : (y_q < -UnitQ) ? -erpt_pkg::Q30One : y_q[31:0];

    a_op  = ph_q ? t_q[erpt_pkg::idx3(i_q, k_q)] : ym[erpt_pkg::idx3(i_q, k_q)];
    b_op  = ph_q ? rm[erpt_pkg::idx3(k_q, j_q)] : pm[erpt_pkg::idx3(k_q, j_q)];
    sum   = acc_q + prod_q;
    res   = 34'(sum >>> 30);
    rv    = 34'((64'(res) + RndAdd) >>> BasisSh);
    e_idx = erpt_pkg::idx3(i_q, j_q);

    case (st_q)
      erpt_pkg::BS_IDLE: begin
        if (stale_q) begin
          stale_d = 1'b0;
          ang_d   = 2'd0;
          quad_d  = phase[31:30];
          it_d    = '0;
          x_d     = 34'(erpt_pkg::CordicGain);
          y_d     = '0;
          z_d     = {3'b000, phase[29:0]};
          st_d    = erpt_pkg::BS_ROT;
        end
      end
      erpt_pkg::BS_ROT: begin
        if (!z_q[32]) begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - erpt_pkg::atan_step(it_q);
        end else begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + erpt_pkg::atan_step(it_q);
        end
        it_d = it_q + 1'b1;
        if (it_q == erpt_pkg::StepW'(erpt_pkg::CordicSteps - 1)) begin
          st_d = erpt_pkg::BS_FIN;
        end
      end
      erpt_pkg::BS_FIN: begin
        case (ang_q)
          2'd1: begin
            case (quad_q)
              2'd0:    begin c_d[1] = xc;  s_d[1] = yc;  end
              2'd1:    begin c_d[1] = -yc; s_d[1] = xc;  end
              2'd2:    begin c_d[1] = -xc; s_d[1] = -yc; end
              default: begin c_d[1] = yc;  s_d[1] = -xc; end
            endcase
          end
          2'd2: begin
            case (quad_q)
              2'd0:    begin c_d[2] = xc;  s_d[2] = yc;  end
              2'd1:    begin c_d[2] = -yc; s_d[2] = xc;  end
              2'd2:    begin c_d[2] = -xc; s_d[2] = -yc; end
              default: begin c_d[2] = yc;  s_d[2] = -xc; end
            endcase
          end
          default: begin
            case (quad_q)
              2'd0:    begin c_d[0] = xc;  s_d[0] = yc;  end
              2'd1:    begin c_d[0] = -yc; s_d[0] = xc;  end
              2'd2:    begin c_d[0] = -xc; s_d[0] = -yc; end
              default: begin c_d[0] = yc;  s_d[0] = -xc; end
            endcase
          end
        endcase
        if (ang_q == 2'd2) begin
          ph_d  = 1'b0;
          sub_d = 1'b0;
          i_d   = '0;
          j_d   = '0;
          k_d   = '0;
          acc_d = 64'sd1 <<< 29;
          st_d  = erpt_pkg::BS_MAC;
        end else begin
          ang_d  = ang_q + 2'd1;
          quad_d = phase[31:30];
          it_d   = '0;
          x_d    = 34'(erpt_pkg::CordicGain);
          y_d    = '0;
          z_d    = {3'b000, phase[29:0]};
          st_d   = erpt_pkg::BS_ROT;
        end
      end
      erpt_pkg::BS_MAC: begin
        sub_d = !sub_q;
        if (!sub_q) begin
          prod_d = 64'(a_op) * 64'(b_op);
        end else if (k_q != 2'd2) begin
          acc_d = sum;
          k_d   = k_q + 2'd1;
        end else begin
          if (!ph_q) begin
            t_d[e_idx] = res[31:0];
          end else begin
            basis_d[e_idx] = (rv > UnitB) ? erpt_pkg::BasisW'(UnitB) :
                             (rv < -UnitB) ? erpt_pkg::BasisW'(-UnitB) :
                             rv[erpt_pkg::BasisW-1:0];
          end
          acc_d = 64'sd1 <<< 29;
          k_d   = '0;
          if (j_q != 2'd2) begin
            j_d = j_q + 2'd1;
          end else begin
            j_d = '0;
            if (i_q != 2'd2) begin
              i_d = i_q + 2'd1;
            end else begin
              i_d = '0;
              if (!ph_q) begin
                ph_d = 1'b1;
              end else begin
                st_d = erpt_pkg::BS_IDLE;
              end
            end
          end
        end
      end
      default: st_d = erpt_pkg::BS_IDLE;
    endcase

    if (stale_set_i) begin
      stale_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= erpt_pkg::BS_IDLE;
      stale_q <= 1'b1;
      basis_q <= erpt_pkg::ident_basis();
    end else begin
      st_q    <= st_d;
      stale_q <= stale_d;
      basis_q <= basis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ang_q  <= ang_d;
    quad_q <= quad_d;
    it_q   <= it_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    c_q    <= c_d;
    s_q    <= s_d;
    ph_q   <= ph_d;
    sub_q  <= sub_d;
    i_q    <= i_d;
    j_q    <= j_d;
    k_q    <= k_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    t_q    <= t_d;
  end

endmodule

// ----- rtl/erpt_back.sv -----
// back end: offset, basis products, rounding and saturation pipeline
module erpt_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  avail_i,
  input  erpt_pkg::request_t    req_i,
  output logic                  pop_o,
  input  erpt_pkg::basis_t      basis_i,
  input  erpt_pkg::vec_t        off_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output erpt_pkg::coord_t      result_x_o,
  output erpt_pkg::coord_t      result_y_o,
  output erpt_pkg::coord_t      result_z_o,
  output logic                  clipped_o
);

  localparam int unsigned RW = erpt_pkg::SumW + 1;
  localparam logic signed [RW-1:0] MaxV = RW'((64'sd1 <<< (erpt_pkg::CoordW - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] MinV = -MaxV - RW'(1);
  localparam logic signed [erpt_pkg::SumW-1:0] RoundHalf =
    erpt_pkg::SumW'(64'sd1 <<< (erpt_pkg::BasisFb - 1));

  logic                               adv;
  logic                               v1_q, v2_q, v3_q, out_valid_q;
  erpt_pkg::action_e                  a1_q, a2_q, a3_q;
  logic signed [erpt_pkg::DiffW-1:0]  d1_q [3];
  logic signed [erpt_pkg::BasisW-1:0] c1_q [3][3];
  logic signed [erpt_pkg::ProdW-1:0]  p2_q [3][3];
  logic signed [erpt_pkg::SumW-1:0]   s3_q [3];
  erpt_pkg::coord_t                   res_q [3];
  logic                               clip_q;

  erpt_pkg::coord_t                   pt [3], of [3];
  logic signed [erpt_pkg::DiffW-1:0]  d1_d [3];
  logic signed [erpt_pkg::BasisW-1:0] c1_d [3][3];
  logic signed [RW-1:0]               r4 [3];
  erpt_pkg::coord_t                   res_d [3];
  logic                               clip_d;

  assign adv         = !out_valid_q || !out_stall_i;
  assign pop_o       = adv && avail_i;
  assign out_valid_o = out_valid_q;
  assign result_x_o  = res_q[0];
  assign result_y_o  = res_q[1];
  assign result_z_o  = res_q[2];
  assign clipped_o   = clip_q;

  always_comb begin
    pt = '{req_i.p.x, req_i.p.y, req_i.p.z};
    of = '{off_i.x, off_i.y, off_i.z};
    for (int k = 0; k < 3; k++) begin
      if (req_i.action == erpt_pkg::ACT_TO_LOCAL) begin
        d1_d[k] = erpt_pkg::DiffW'(pt[k]) - erpt_pkg::DiffW'(of[k]);
      end else begin
        d1_d[k] = erpt_pkg::DiffW'(pt[k]);
      end
      for (int m = 0; m < 3; m++) begin
        c1_d[k][m] = (req_i.action == erpt_pkg::ACT_TO_LOCAL) ?
                     $signed(basis_i[3*m+k]) : $signed(basis_i[3*k+m]);
      end
    end
  end

  always_comb begin
    clip_d = 1'b0;
    for (int k = 0; k < 3; k++) begin
      r4[k] = RW'(s3_q[k] >>> erpt_pkg::BasisFb);
      if (a3_q == erpt_pkg::ACT_TO_WORLD) begin
        r4[k] = r4[k] + RW'(of[k]);
      end
      if (r4[k] > MaxV) begin
        res_d[k] = MaxV[erpt_pkg::CoordW-1:0];
        clip_d   = 1'b1;
      end else if (r4[k] < MinV) begin
        res_d[k] = MinV[erpt_pkg::CoordW-1:0];
        clip_d   = 1'b1;
      end else begin
        res_d[k] = r4[k][erpt_pkg::CoordW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= avail_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a1_q   <= req_i.action;
      a2_q   <= a1_q;
      a3_q   <= a2_q;
      d1_q   <= d1_d;
      c1_q   <= c1_d;
      for (int k = 0; k < 3; k++) begin
        for (int m = 0; m < 3; m++) begin
          p2_q[k][m] <= erpt_pkg::ProdW'(c1_q[k][m]) * erpt_pkg::ProdW'(d1_q[m]);
        end
        s3_q[k] <= erpt_pkg::SumW'(p2_q[k][0]) + erpt_pkg::SumW'(p2_q[k][1]) +
                   erpt_pkg::SumW'(p2_q[k][2]) + RoundHalf;
      end
      res_q  <= res_d;
      clip_q <= clip_d;
    end
  end

endmodule

// ----- rtl/euler_rigid_point_transform.sv -----
// top level: configuration registers, request queue, basis builder and transform pipeline
// One point enters per clock while in_stall_o is low, and results leave one per clock
// through the registered multiply-add pipeline of the back end while out_stall_i is low;
// a four-entry queue separates intake from the pipeline. After reset and after any angle
// write the basis is rebuilt by a shared CORDIC for the three angles and a single
// multiplier for both 3x3 products, during which in_stall_o stays high.
module euler_rigid_point_transform (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [erpt_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [erpt_pkg::CfgW-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                action_i,
  input  logic signed [erpt_pkg::CoordW-1:0]  point_x_i,
  input  logic signed [erpt_pkg::CoordW-1:0]  point_y_i,
  input  logic signed [erpt_pkg::CoordW-1:0]  point_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [erpt_pkg::CoordW-1:0]  result_x_o,
  output logic signed [erpt_pkg::CoordW-1:0]  result_y_o,
  output logic signed [erpt_pkg::CoordW-1:0]  result_z_o,
  output logic                                clipped_o
);

  logic [erpt_pkg::AngleW-1:0] pitch_q, pitch_d, yaw_q, yaw_d, roll_q, roll_d;
  erpt_pkg::vec_t              off_q, off_d;
  logic                        angle_wr;
  erpt_pkg::request_t          req_in, req_q;
  erpt_pkg::basis_t            basis;
  logic                        basis_busy, avail, pop;

  always_comb begin
    pitch_d  = pitch_q;
    yaw_d    = yaw_q;
    roll_d   = roll_q;
    off_d    = off_q;
    angle_wr = 1'b0;
    if (cfg_we_i) begin
      case (erpt_pkg::cfg_reg_e'(cfg_idx_i))
        erpt_pkg::REG_PITCH: begin
          pitch_d  = cfg_data_i[erpt_pkg::AngleW-1:0];
          angle_wr = 1'b1;
        end
        erpt_pkg::REG_YAW: begin
          yaw_d    = cfg_data_i[erpt_pkg::AngleW-1:0];
          angle_wr = 1'b1;
        end
        erpt_pkg::REG_ROLL: begin
          roll_d   = cfg_data_i[erpt_pkg::AngleW-1:0];
          angle_wr = 1'b1;
        end
        erpt_pkg::REG_OFFSET_X: off_d.x = cfg_data_i[erpt_pkg::CoordW-1:0];
        erpt_pkg::REG_OFFSET_Y: off_d.y = cfg_data_i[erpt_pkg::CoordW-1:0];
        erpt_pkg::REG_OFFSET_Z: off_d.z = cfg_data_i[erpt_pkg::CoordW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q <= '0;
      yaw_q   <= '0;
      roll_q  <= '0;
      off_q   <= '0;
    end else begin
      pitch_q <= pitch_d;
      yaw_q   <= yaw_d;
      roll_q  <= roll_d;
      off_q   <= off_d;
    end
  end

  assign req_in.action = erpt_pkg::action_e'(action_i);
  assign req_in.p.x    = point_x_i;
  assign req_in.p.y    = point_y_i;
  assign req_in.p.z    = point_z_i;

  erpt_basis u_basis (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stale_set_i (angle_wr),
    .pitch_i     (pitch_q),
    .yaw_i       (yaw_q),
    .roll_i      (roll_q),
    .busy_o      (basis_busy),
    .basis_o     (basis)
  );

  erpt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .req_i        (req_in),
    .basis_busy_i (basis_busy),
    .stall_o      (in_stall_o),
    .pop_i        (pop),
    .avail_o      (avail),
    .req_o        (req_q)
  );

  erpt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (avail),
    .req_i       (req_q),
    .pop_o       (pop),
    .basis_i     (basis),
    .off_i       (off_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_x_o  (result_x_o),
    .result_y_o  (result_y_o),
    .result_z_o  (result_z_o),
    .clipped_o   (clipped_o)
  );

endmodule

// ----- verif/euler_rigid_point_transform_test.sv -----
// testbench for the euler rigid point transform: directed and random points against a predictor
`timescale 1ns / 1ps

module euler_rigid_point_transform_test;
  import erpt_pkg::*;

  localparam logic [CfgIdxW-1:0] RegSpare6 = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpare7 = 3'd7;
  localparam longint CoordMax = 64'sd2147483647;
  localparam longint CoordMin = -64'sd2147483648;
  localparam longint QOne = 64'sd1 << 30;
  localparam longint BOne = 64'sd1 << BasisFb;

  typedef longint mat9_t [9];

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   clip;
  } point_result_t;

  localparam longint ArcTan [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81};

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgW-1:0]     cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic                action;
  coord_t              point_x, point_y, point_z;
  logic                out_valid;
  logic                out_stall;
  coord_t              result_x, result_y, result_z;
  logic                clipped;

  // predictor state
  logic [AngleW-1:0] ang_pitch, ang_yaw, ang_roll;
  coord_t            off_x, off_y, off_z;
  mat9_t             rot;
  logic              rot_stale;

  point_result_t     pending_results[$];
  int unsigned       err_cnt;
  int unsigned       burst_left;
  int unsigned       gap_max;
  int unsigned       stall_pct;
  int unsigned       hold_cycles;

  euler_rigid_point_transform uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .action_i    (action),
    .point_x_i   (point_x),
    .point_y_i   (point_y),
    .point_z_i   (point_z),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .result_x_o  (result_x),
    .result_y_o  (result_y),
    .result_z_o  (result_z),
    .clipped_o   (clipped)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void sin_cos(input logic [AngleW-1:0] a, output longint c,
                                  output longint s);
    logic [31:0] ph;
    longint x, y, z, dx, dy;
    ph = {a, 16'h0000};
    z = longint'({34'd0, ph[29:0]});
    x = CordicGain;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ArcTan[i];
      end else begin
        x += dx; y -= dy; z += ArcTan[i];
      end
    end
    if (x > QOne) x = QOne;
    if (x < -QOne) x = -QOne;
    if (y > QOne) y = QOne;
    if (y < -QOne) y = -QOne;
    case (ph[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic mat9_t mul_q30(input mat9_t a, input mat9_t b);
    mat9_t r;
    longint acc;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 64'sd1 << 29;
        for (int k = 0; k < 3; k++) acc += a[i*3+k] * b[k*3+j];
        r[i*3+j] = acc >>> 30;
      end
    return r;
  endfunction

  function automatic void rebuild_rotation();
    longint cp, sp, cy, sy, cr, sr, v;
    mat9_t ym, pm, rm, u;
    sin_cos(ang_pitch, cp, sp);
    sin_cos(ang_yaw, cy, sy);
    sin_cos(ang_roll, cr, sr);
    ym = '{cy, 0, -sy, 0, QOne, 0, sy, 0, cy};
    pm = '{QOne, 0, 0, 0, cp, sp, 0, -sp, cp};
    rm = '{cr, -sr, 0, sr, cr, 0, 0, 0, QOne};
    u = mul_q30(mul_q30(ym, pm), rm);
    for (int i = 0; i < 9; i++) begin
      v = (u[i] + (64'sd1 << (29 - BasisFb))) >>> (30 - BasisFb);
      if (v > BOne) v = BOne;
      if (v < -BOne) v = -BOne;
      rot[i] = v;
    end
    rot_stale = 1'b0;
  endfunction

  function automatic longint row_dot(input longint b0, b1, b2, v0, v1, v2);
    return (b0 * v0 + b1 * v1 + b2 * v2 + (64'sd1 << (BasisFb - 1))) >>> BasisFb;
  endfunction

  function automatic coord_t clamp_coord(input longint v, inout logic clip);
    if (v > CoordMax) begin clip = 1'b1; return coord_t'(CoordMax); end
    if (v < CoordMin) begin clip = 1'b1; return coord_t'(CoordMin); end
    return coord_t'(v);
  endfunction

  function automatic point_result_t transform_point(input action_e act, input coord_t px,
                                                    input coord_t py, input coord_t pz);
    point_result_t res;
    longint p [3];
    longint o [3];
    longint r [3];
    p = '{longint'(px), longint'(py), longint'(pz)};
    o = '{longint'(off_x), longint'(off_y), longint'(off_z)};
    if (rot_stale) rebuild_rotation();
    if (act == ACT_TO_WORLD) begin
      for (int k = 0; k < 3; k++)
        r[k] = row_dot(rot[k*3], rot[k*3+1], rot[k*3+2], p[0], p[1], p[2]) + o[k];
    end else begin
      for (int k = 0; k < 3; k++) p[k] -= o[k];
      for (int k = 0; k < 3; k++)
        r[k] = row_dot(rot[k], rot[3+k], rot[6+k], p[0], p[1], p[2]);
    end
    res.clip = 1'b0;
    res.x = clamp_coord(r[0], res.clip);
    res.y = clamp_coord(r[1], res.clip);
    res.z = clamp_coord(r[2], res.clip);
    return res;
  endfunction

  // result checker
  always @(posedge clk) begin
    point_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result %h %h %h", result_x, result_y, result_z);
      end else begin
        exp_res = pending_results.pop_front();
        if (result_x !== exp_res.x || result_y !== exp_res.y || result_z !== exp_res.z ||
            clipped !== exp_res.clip) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: expected %h %h %h clip %b, got %h %h %h clip %b",
                     exp_res.x, exp_res.y, exp_res.z, exp_res.clip,
                     result_x, result_y, result_z, clipped);
        end
      end
    end
  end

  // receiver stall pattern with optional long hold-off
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PITCH:    begin ang_pitch = data[AngleW-1:0]; rot_stale = 1'b1; end
      REG_YAW:      begin ang_yaw = data[AngleW-1:0]; rot_stale = 1'b1; end
      REG_ROLL:     begin ang_roll = data[AngleW-1:0]; rot_stale = 1'b1; end
      REG_OFFSET_X: off_x = data;
      REG_OFFSET_Y: off_y = data;
      REG_OFFSET_Z: off_z = data;
      default: ;
    endcase
  endtask

  task automatic set_pose(input logic [CfgW-1:0] p, y, r, ox, oy, oz);
    write_reg(REG_PITCH, p);
    write_reg(REG_YAW, y);
    write_reg(REG_ROLL, r);
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
    write_reg(REG_OFFSET_Z, oz);
  endtask

  task automatic send_point(input action_e act, input coord_t px, input coord_t py,
                            input coord_t pz);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    action   <= act;
    point_x  <= px;
    point_y  <= py;
    point_z  <= pz;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(transform_point(act, px, py, pz));
    burst_left--;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(5))
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 2 * 65536 * 100)) - 65536 * 100);
      2: return $urandom_range(1) ? coord_t'(CoordMax) : coord_t'(CoordMin);
      3: return coord_t'($signed($urandom_range(0, 2000)) - 1000);
      default: return coord_t'($signed($urandom_range(0, 2 * 65536 * 8000)) - 65536 * 8000);
    endcase
  endfunction

  function automatic logic [CfgW-1:0] rand_angle();
    case ($urandom_range(4))
      0: return $urandom;
      1: return CfgW'(($urandom_range(7) << 13) | $urandom_range(3));
      default: return CfgW'($urandom_range(16'hffff));
    endcase
  endfunction

  task automatic test_directed();
    // default pose after reset, rebuild on first point
    send_point(ACT_TO_WORLD, 32'sd65536, -32'sd131072, 32'sd0);
    send_point(ACT_TO_LOCAL, coord_t'(CoordMax), coord_t'(CoordMin), 32'sd1);
    send_point(ACT_TO_WORLD, coord_t'(CoordMin), coord_t'(CoordMax), -32'sd1);
    drain();
    // saturation in both modes, wide difference in to-local
    set_pose(0, 0, 0, coord_t'(CoordMax), coord_t'(CoordMin), 32'sd65536);
    send_point(ACT_TO_WORLD, coord_t'(CoordMax), coord_t'(CoordMin), coord_t'(CoordMax));
    send_point(ACT_TO_LOCAL, coord_t'(CoordMin), coord_t'(CoordMax), coord_t'(CoordMin));
    send_point(ACT_TO_LOCAL, 32'sd0, 32'sd0, 32'sd0);
    drain();
    // extreme angles and multiples of a quarter turn
    set_pose(32'h0000_8000, 32'h0000_7fff, 32'h0000_4000, 32'sd1, -32'sd1, 32'sd0);
    send_point(ACT_TO_WORLD, 32'sd65536, 32'sd65536, 32'sd65536);
    send_point(ACT_TO_LOCAL, coord_t'(CoordMax), coord_t'(CoordMax), coord_t'(CoordMax));
    drain();
    set_pose(32'h0000_c000, 32'h0000_8000, 32'h0000_ffff, 32'sd0, 32'sd0, 32'sd0);
    send_point(ACT_TO_WORLD, coord_t'(CoordMin), coord_t'(CoordMin), coord_t'(CoordMin));
    send_point(ACT_TO_LOCAL, 32'sd12345, -32'sd54321, 32'sd99);
    drain();
    // upper data bits on angle writes are dropped
    set_pose(32'hffff_2000, 32'h1234_e000, 32'h8000_0001, 32'sh7fff_0000, 32'sh8000_ffff,
             32'sh0001_8000);
    send_point(ACT_TO_WORLD, 32'sd1000, 32'sd2000, 32'sd3000);
    send_point(ACT_TO_LOCAL, 32'sd1000, 32'sd2000, 32'sd3000);
    drain();
    // writes to unused register indexes change nothing
    write_reg(RegSpare6, 32'hffff_ffff);
    write_reg(RegSpare7, 32'h0000_5555);
    send_point(ACT_TO_WORLD, 32'sd1000, 32'sd2000, 32'sd3000);
    send_point(ACT_TO_LOCAL, -32'sd65536, 32'sd65536, 32'sd7);
    drain();
  endtask

  task automatic test_random(input int unsigned n_phases, input int unsigned per_phase);
    for (int ph = 0; ph < n_phases; ph++) begin
      stall_pct = (ph % 4 == 0) ? 0 : $urandom_range(70);
      gap_max   = (ph % 5 == 1) ? 0 : $urandom_range(1, 6);
      if (ph % 3 == 0) begin
        set_pose(rand_angle(), rand_angle(), rand_angle(), rand_coord(), rand_coord(),
                 rand_coord());
      end else begin
        write_reg(cfg_reg_e'($urandom_range(REG_ROLL)), rand_angle());
        write_reg(cfg_reg_e'($urandom_range(REG_OFFSET_X, REG_OFFSET_Z)), rand_coord());
      end
      for (int i = 0; i < per_phase; i++)
        send_point(action_e'($urandom_range(1)), rand_coord(), rand_coord(), rand_coord());
      drain();
    end
  endtask

  task automatic test_backpressure();
    stall_pct = 20;
    gap_max = 0;
    set_pose(rand_angle(), rand_angle(), rand_angle(), rand_coord(), rand_coord(), rand_coord());
    send_point(ACT_TO_WORLD, rand_coord(), rand_coord(), rand_coord());
    hold_cycles = 300;
    for (int i = 0; i < 40; i++)
      send_point(action_e'($urandom_range(1)), rand_coord(), rand_coord(), rand_coord());
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    action = 1'b0;
    point_x = '0;
    point_y = '0;
    point_z = '0;
    err_cnt = 0;
    burst_left = 0;
    gap_max = 3;
    stall_pct = 25;
    hold_cycles = 0;
    ang_pitch = '0;
    ang_yaw = '0;
    ang_roll = '0;
    off_x = '0;
    off_y = '0;
    off_z = '0;
    rot_stale = 1'b1;
    for (int i = 0; i < 9; i++) rot[i] = (i % 4 == 0) ? BOne : 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random(22, 48);

    repeat (20) @(posedge clk);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
